FILE: rtl/gdcs_pkg.sv
// Shared types, constants and timing tables of the GPS duty-cycle scheduler.
`timescale 1ns / 1ps
package gdcs_pkg;

  localparam int unsigned BUFFER_DEPTH_DEF = 64;
  localparam int unsigned CMD_QUEUE_DEPTH  = 2;
  localparam int unsigned RES_QUEUE_DEPTH  = 2;

  localparam int unsigned TICKS_PER_MIN  = 6000;
  localparam int unsigned TICK_W         = 19;  // 60 min * 6000 ticks fits
  localparam logic [7:0]  DEF_INTERVAL   = 8'd3;
  localparam logic [7:0]  GET_MIN_LO     = 8'd1;
  localparam logic [7:0]  SEND_MIN_LO    = 8'd3;
  localparam logic [7:0]  INTERVAL_HI    = 8'd60;

  localparam logic [2:0]  BACKOFF_NONE   = 3'd4;
  localparam int unsigned MODE_AUTO_BIT  = 0;
  localparam int unsigned MODE_MAN_BIT   = 1;

  localparam int unsigned CFG_ADDR_W     = 4;

  typedef enum logic [1:0] {
    REG_GPS_ENABLE   = 2'd0,
    REG_GET_INTERVAL = 2'd1,
    REG_SEND_INTERVAL= 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    KIND_POLL    = 2'd0,
    KIND_FIX     = 2'd1,
    KIND_MANUAL  = 2'd2,
    KIND_STARTED = 2'd3
  } kind_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] now;
    logic        sim_ready;
    logic [23:0] lat_prefix;
    logic [31:0] long_prefix;
    logic        manual_on;
  } in_item_t;

  typedef struct packed {
    logic        open_cmd;
    logic        close_cmd;
    logic        record_fix;
    logic [23:0] record_lat;
    logic [31:0] record_long;
    logic        flush;
    logic [7:0]  flush_count;
    logic [1:0]  work_mode;
    logic        manual_rejected;
  } out_item_t;

  // Classified event as it waits between front and back.
  typedef struct packed {
    kind_t       kind;
    logic [31:0] now;
    logic        sim_ready;
    logic [55:0] fix;
    logic        manual_on;
  } cmd_t;

  // Qualified configuration handed to the back end.
  typedef struct packed {
    logic              enable;
    logic [TICK_W-1:0] get_ticks;
    logic [TICK_W-1:0] send_ticks;
  } cfg_t;

  function automatic logic [31:0] run_window_ticks(input logic [1:0] idx);
    case (idx)
      2'd0:    run_window_ticks = 32'd30000;
      2'd1:    run_window_ticks = 32'd18000;
      2'd2:    run_window_ticks = 32'd6000;
      default: run_window_ticks = 32'd3500;
    endcase
  endfunction

  function automatic logic [31:0] backoff_ticks(input logic [1:0] idx);
    case (idx)
      2'd0:    backoff_ticks = 32'd30000;
      2'd1:    backoff_ticks = 32'd60000;
      2'd2:    backoff_ticks = 32'd90000;
      default: backoff_ticks = 32'd120000;
    endcase
  endfunction

endpackage

FILE: rtl/gdcs_fifo.sv
// Small register queue with first-word fall-through read.
`timescale 1ns / 1ps
module gdcs_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

FILE: rtl/gdcs_front.sv
// Front end: classify incoming events and qualify the interval settings.
`timescale 1ns / 1ps
module gdcs_front
  import gdcs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  in_item_t   in_data,
  input  logic       enable,
  input  logic [7:0] get_min,
  input  logic [7:0] send_min,
  output cmd_t       cmd,
  output cfg_t       cfg
);

  logic [5:0]        get_sel, send_sel;
  logic [TICK_W-1:0] get_ticks_nxt, send_ticks_nxt;
  logic [TICK_W-1:0] get_ticks_r, send_ticks_r;
  logic              enable_r;

  // Fall back to three minutes outside the legal range.
  assign get_sel  = (get_min >= GET_MIN_LO && get_min <= INTERVAL_HI)
                    ? get_min[5:0] : DEF_INTERVAL[5:0];
  assign send_sel = (send_min >= SEND_MIN_LO && send_min <= INTERVAL_HI)
                    ? send_min[5:0] : DEF_INTERVAL[5:0];

  assign get_ticks_nxt  = TICK_W'(get_sel)  * TICK_W'(TICKS_PER_MIN);
  assign send_ticks_nxt = TICK_W'(send_sel) * TICK_W'(TICKS_PER_MIN);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r     <= 1'b0;
      get_ticks_r  <= TICK_W'(DEF_INTERVAL) * TICK_W'(TICKS_PER_MIN);
      send_ticks_r <= TICK_W'(DEF_INTERVAL) * TICK_W'(TICKS_PER_MIN);
    end else begin
      enable_r     <= enable;
      get_ticks_r  <= get_ticks_nxt;
      send_ticks_r <= send_ticks_nxt;
    end
  end

  assign cfg.enable     = enable_r;
  assign cfg.get_ticks  = get_ticks_r;
  assign cfg.send_ticks = send_ticks_r;

  always_comb begin
    cmd.kind      = kind_t'(in_data.kind);
    cmd.now       = in_data.now;
    cmd.sim_ready = in_data.sim_ready;
    cmd.fix       = {in_data.lat_prefix, in_data.long_prefix};
    cmd.manual_on = in_data.manual_on;
  end

endmodule

FILE: rtl/gdcs_back.sv
// Back end: scheduler state and per-event update, one event per cycle while the result queue has room.
`timescale 1ns / 1ps
module gdcs_back
  import gdcs_pkg::*;
#(
  parameter int unsigned BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  cmd_t      cmd,
  input  logic      cmd_empty,
  output logic      cmd_pop,
  input  logic      res_full,
  output logic      res_push,
  output out_item_t res
);

  logic [31:0] last_get_r,   last_get_nxt;
  logic [31:0] last_send_r,  last_send_nxt;
  logic [31:0] run_start_r,  run_start_nxt;
  logic [31:0] delay_start_r, delay_start_nxt;
  logic        delay_r,      delay_nxt;
  logic [1:0]  win_idx_r,    win_idx_nxt;
  logic [2:0]  backoff_r,    backoff_nxt;
  logic [1:0]  mode_r,       mode_nxt;
  logic        pending_r,    pending_nxt;
  logic [55:0] latest_r,     latest_nxt;
  logic [55:0] recorded_r,   recorded_nxt;
  logic [7:0]  count_r,      count_nxt;

  logic        take;
  logic [31:0] el_delay, el_get, el_send, el_run;

  assign take     = !cmd_empty && !res_full;
  assign cmd_pop  = take;
  assign res_push = take;

  assign el_delay = cmd.now - delay_start_r;
  assign el_get   = cmd.now - last_get_r;
  assign el_send  = cmd.now - last_send_r;
  assign el_run   = cmd.now - run_start_r;

  always_comb begin
    last_get_nxt    = last_get_r;
    last_send_nxt   = last_send_r;
    run_start_nxt   = run_start_r;
    delay_start_nxt = delay_start_r;
    delay_nxt       = delay_r;
    win_idx_nxt     = win_idx_r;
    backoff_nxt     = backoff_r;
    mode_nxt        = mode_r;
    pending_nxt     = pending_r;
    latest_nxt      = latest_r;
    recorded_nxt    = recorded_r;
    count_nxt       = count_r;
    res             = '0;

    if (take) begin
      case (cmd.kind)
        KIND_POLL: begin
          if (delay_r && !backoff_r[2]) begin
            // Backoff running: only watch for its end.
            if (el_delay >= backoff_ticks(backoff_r[1:0])) begin
              delay_nxt = 1'b0;
            end
          end else begin
            if (cfg.enable && cmd.sim_ready) begin
              if (el_get >= 32'(cfg.get_ticks)) begin
                last_get_nxt            = cmd.now;
                mode_nxt[MODE_AUTO_BIT] = 1'b1;
                res.open_cmd            = 1'b1;
              end
              if (el_send >= 32'(cfg.send_ticks)) begin
                last_send_nxt = cmd.now;
                if (count_nxt != '0) begin
                  res.flush       = 1'b1;
                  res.flush_count = count_nxt;
                  count_nxt       = '0;
                end
              end
            end
            if (mode_nxt[MODE_AUTO_BIT]) begin
              if (el_run < run_window_ticks(win_idx_r)) begin
                if (pending_r) begin
                  if (!mode_nxt[MODE_MAN_BIT]) begin
                    res.close_cmd = 1'b1;
                  end
                  if (count_nxt < 8'(BUFFER_DEPTH) && latest_r != recorded_r) begin
                    recorded_nxt    = latest_r;
                    res.record_fix  = 1'b1;
                    res.record_lat  = latest_r[55:32];
                    res.record_long = latest_r[31:0];
                    count_nxt       = count_nxt + 8'd1;
                  end
                  pending_nxt             = 1'b0;
                  mode_nxt[MODE_AUTO_BIT] = 1'b0;
                  // Tighten the window to the shortest one the fix beat.
                  if (el_run < run_window_ticks(2'd3)) begin
                    win_idx_nxt = 2'd3;
                  end else if (el_run < run_window_ticks(2'd2)) begin
                    win_idx_nxt = 2'd2;
                  end else if (el_run < run_window_ticks(2'd1)) begin
                    win_idx_nxt = 2'd1;
                  end
                  backoff_nxt = BACKOFF_NONE;
                end
              end else begin
                if (!mode_nxt[MODE_MAN_BIT]) begin
                  res.close_cmd           = 1'b1;
                  mode_nxt[MODE_AUTO_BIT] = 1'b0;
                  delay_start_nxt         = cmd.now;
                  delay_nxt               = 1'b1;
                  if (win_idx_r != '0) begin
                    win_idx_nxt = win_idx_r - 2'd1;
                  end
                  backoff_nxt = backoff_r[2] ? 3'd0 : backoff_r + 3'd1;
                end
                run_start_nxt = cmd.now;
              end
            end
          end
        end
        KIND_FIX: begin
          latest_nxt  = cmd.fix;
          pending_nxt = 1'b1;
        end
        KIND_MANUAL: begin
          if (!cfg.enable) begin
            res.manual_rejected = 1'b1;
          end else begin
            mode_nxt[MODE_MAN_BIT] = cmd.manual_on;
            if (!mode_nxt[MODE_AUTO_BIT]) begin
              res.open_cmd  = cmd.manual_on;
              res.close_cmd = !cmd.manual_on;
            end
          end
        end
        KIND_STARTED: begin
          run_start_nxt = cmd.now;
        end
        default: begin
          run_start_nxt = run_start_r;
        end
      endcase
      res.work_mode = mode_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_get_r    <= '0;
      last_send_r   <= '0;
      run_start_r   <= '0;
      delay_start_r <= '0;
      delay_r       <= 1'b0;
      win_idx_r     <= '0;
      backoff_r     <= BACKOFF_NONE;
      mode_r        <= '0;
      pending_r     <= 1'b0;
      latest_r      <= '0;
      recorded_r    <= '0;
      count_r       <= '0;
    end else begin
      last_get_r    <= last_get_nxt;
      last_send_r   <= last_send_nxt;
      run_start_r   <= run_start_nxt;
      delay_start_r <= delay_start_nxt;
      delay_r       <= delay_nxt;
      win_idx_r     <= win_idx_nxt;
      backoff_r     <= backoff_nxt;
      mode_r        <= mode_nxt;
      pending_r     <= pending_nxt;
      latest_r      <= latest_nxt;
      recorded_r    <= recorded_nxt;
      count_r       <= count_nxt;
    end
  end

endmodule

FILE: rtl/gps_duty_cycle_scheduler.sv
// Top level of the GPS duty-cycle scheduler: config registers, queues, front and back.
`timescale 1ns / 1ps
// Power duty-cycle controller for a GPS receiver. Each input word is one event
// (poll, fix arrived, manual request, receiver started) and produces exactly one
// result word carrying open/close commands, a recorded fix, a flush count and the
// mode bits. Sustained rate is one word per cycle while the result side keeps
// popping: a pushed word is written into the command queue, taken from there by
// the back end, whose update is combinational, and written into the result
// queue, whose head shows on the result ports. Two-entry queues before and after
// the back end let the input and result sides stall independently. Interval
// registers are range checked and converted to ticks in a register stage, so
// write them only while no events are in flight. Register map (32-bit APB, pready
// tied high): 0x0 gps_enable, 0x4 get_interval_min, 0x8 send_interval_min.
module gps_duty_cycle_scheduler
  import gdcs_pkg::*;
#(
  parameter int unsigned BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // event input
  input  logic                  push,
  output logic                  full,
  input  in_item_t              in_data,
  // result output
  output logic                  empty,
  input  logic                  pop,
  output out_item_t             out_data,
  // configuration
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  logic        enable_r;
  logic [7:0]  get_min_r, send_min_r;
  logic        cfg_wr;
  reg_idx_t    cfg_idx;

  cmd_t        cmd_in, cmd_out;
  cfg_t        qual_cfg;
  logic        cmd_empty, cmd_pop;
  logic        res_full, res_push;
  out_item_t   res;

  // Register file: word index from address bits [3:2].
  assign pready  = 1'b1;
  assign cfg_idx = reg_idx_t'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r   <= 1'b0;
      get_min_r  <= DEF_INTERVAL;
      send_min_r <= DEF_INTERVAL;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_GPS_ENABLE:    enable_r   <= pwdata[0];
        REG_GET_INTERVAL:  get_min_r  <= pwdata[7:0];
        REG_SEND_INTERVAL: send_min_r <= pwdata[7:0];
        default:           enable_r   <= enable_r;   // unmapped: drop the write
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_GPS_ENABLE:    prdata = {31'd0, enable_r};
      REG_GET_INTERVAL:  prdata = {24'd0, get_min_r};
      REG_SEND_INTERVAL: prdata = {24'd0, send_min_r};
      default:           prdata = '0;
    endcase
  end

  // Front: classify the event and qualify intervals.
  gdcs_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .enable   (enable_r),
    .get_min  (get_min_r),
    .send_min (send_min_r),
    .cmd      (cmd_in),
    .cfg      (qual_cfg)
  );

  // Hold classified events until the back end can take them.
  gdcs_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (CMD_QUEUE_DEPTH)
  ) u_cmd_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_data (cmd_in),
    .full    (full),
    .pop     (cmd_pop),
    .rd_data (cmd_out),
    .empty   (cmd_empty)
  );

  // Back: advance the scheduler state, one event per cycle while the result queue has room.
  gdcs_back #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (qual_cfg),
    .cmd       (cmd_out),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res)
  );

  // Result words wait here for the consumer.
  gdcs_fifo #(
    .WIDTH ($bits(out_item_t)),
    .DEPTH (RES_QUEUE_DEPTH)
  ) u_res_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (res_push),
    .wr_data (res),
    .full    (res_full),
    .pop     (pop),
    .rd_data (out_data),
    .empty   (empty)
  );

endmodule

FILE: rtl/gdcs_checker.sv
// Port-level checks for the GPS duty-cycle scheduler, bound to the top level.
`timescale 1ns / 1ps
module gdcs_checker
  import gdcs_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      empty,
  input logic      pop,
  input out_item_t out_data
);

  // Nothing is waiting right after reset.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> empty)
    else $error("result queue not empty after reset");

  // A waiting result holds while not popped.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && !pop |=> !empty && $stable(out_data))
    else $error("waiting result changed or vanished");

  // Record fields are zero unless a fix was recorded.
  a_record_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && !out_data.record_fix |->
      out_data.record_lat == '0 && out_data.record_long == '0)
    else $error("record fields set without record_fix");

  // A flush always hands off records; its count is zero otherwise.
  a_flush_count: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (out_data.flush == (out_data.flush_count != '0)))
    else $error("flush and flush_count disagree");

  // A rejected manual request does nothing else.
  a_reject_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && out_data.manual_rejected |->
      !out_data.open_cmd && !out_data.close_cmd &&
      !out_data.record_fix && !out_data.flush)
    else $error("rejected manual request produced commands");

endmodule

bind gps_duty_cycle_scheduler gdcs_checker u_gdcs_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .empty    (empty),
  .pop      (pop),
  .out_data (out_data)
);

FILE: dv/gps_duty_cycle_scheduler_test.sv
// Self-checking testbench for the GPS duty-cycle scheduler: directed table, then random episodes.
`timescale 1ns / 1ps
module gps_duty_cycle_scheduler_test;
  import gdcs_pkg::*;

  // Run window and close backoff lengths in ticks, entry 0 on the right.
  localparam logic [3:0][31:0] RUN_SPAN     = {32'd3500, 32'd6000, 32'd18000, 32'd30000};
  localparam logic [3:0][31:0] BACKOFF_SPAN = {32'd120000, 32'd90000, 32'd60000, 32'd30000};
  localparam int unsigned      STALL_LIMIT  = 20000;

  // A result word either comes from the predictor or is pinned by the directed table.
  typedef struct packed {
    logic      pinned;
    out_item_t word;
  } pin_t;

  typedef struct packed {
    in_item_t  word;
    logic      pinned;
    out_item_t want;
  } row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        push = 1'b0;
  in_item_t    in_data = '0;
  logic        pop = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic        full;
  logic        empty;
  out_item_t   out_data;
  logic [31:0] prdata;
  logic        pready;

  gps_duty_cycle_scheduler uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (full),
    .in_data (in_data),
    .empty   (empty),
    .pop     (pop),
    .out_data(out_data),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor copy of the configuration registers.
  logic        cfg_enable;
  logic [7:0]  cfg_get_min;
  logic [7:0]  cfg_send_min;

  // Predictor copy of the scheduler state.
  logic [31:0] sch_last_get;
  logic [31:0] sch_last_send;
  logic [31:0] sch_run_start;
  logic [31:0] sch_delay_start;
  logic        sch_delay_on;
  logic [1:0]  sch_window;
  logic [2:0]  sch_backoff;
  logic [1:0]  sch_mode;
  logic        sch_fix_pending;
  logic [55:0] sch_latest_fix;
  logic [55:0] sch_last_recorded;
  logic [7:0]  sch_record_count;

  out_item_t   pending_results[$];   // expected result words, oldest first
  pin_t        pinned_results[$];    // one entry per word handed to the input side
  row_t        plan[$];              // directed stimulus table
  int          mismatches = 0;
  int          words_sent = 0;
  int          stall_cycles = 0;
  bit          calm = 1'b0;          // no idling on either side while set
  logic [31:0] tb_now = '0;          // tick value of the latest event sent
  out_item_t   blank;
  out_item_t   refused;
  out_item_t   exp_word;
  out_item_t   step_word;
  pin_t        pin_entry;

  task automatic note(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endtask

  // Advance the predictor by one event and return the result word it causes.
  function automatic out_item_t schedule_step(input in_item_t w);
    out_item_t   r;
    logic [31:0] dt;
    logic [31:0] span;
    logic [7:0]  mins;
    logic        hit;
    int          i;
    r = '0;
    case (kind_t'(w.kind))
      KIND_POLL: begin
        if (sch_delay_on && sch_backoff < BACKOFF_NONE) begin
          // Backoff in progress: only watch for the delay to run out.
          dt = w.now - sch_delay_start;
          if (dt >= BACKOFF_SPAN[sch_backoff[1:0]]) sch_delay_on = 1'b0;
        end else begin
          if (cfg_enable && w.sim_ready) begin
            mins = (cfg_get_min >= 8'd1 && cfg_get_min <= 8'd60) ? cfg_get_min : 8'd3;
            span = 32'(mins) * 32'd6000;
            dt = w.now - sch_last_get;
            if (dt >= span) begin
              sch_last_get = w.now;
              sch_mode[0] = 1'b1;
              r.open_cmd = 1'b1;
            end
            mins = (cfg_send_min >= 8'd3 && cfg_send_min <= 8'd60) ? cfg_send_min : 8'd3;
            span = 32'(mins) * 32'd6000;
            dt = w.now - sch_last_send;
            if (dt >= span) begin
              sch_last_send = w.now;
              if (sch_record_count != 8'd0) begin
                r.flush = 1'b1;
                r.flush_count = sch_record_count;
                sch_record_count = 8'd0;
              end
            end
          end
          if (sch_mode[0]) begin
            dt = w.now - sch_run_start;
            if (dt < RUN_SPAN[sch_window]) begin
              if (sch_fix_pending) begin
                if (!sch_mode[1]) r.close_cmd = 1'b1;
                if (sch_record_count < 8'(BUFFER_DEPTH_DEF) &&
                    sch_latest_fix != sch_last_recorded)
                begin
                  sch_last_recorded = sch_latest_fix;
                  r.record_fix = 1'b1;
                  r.record_lat = sch_latest_fix[55:32];
                  r.record_long = sch_latest_fix[31:0];
                  sch_record_count = sch_record_count + 8'd1;
                end
                sch_fix_pending = 1'b0;
                sch_mode[0] = 1'b0;
                // Shrink the window to the tightest entry that still covers this run.
                hit = 1'b0;
                for (i = 3; i > 0; i--) begin
                  if (!hit && dt < RUN_SPAN[i]) begin
                    sch_window = i[1:0];
                    hit = 1'b1;
                  end
                end
                sch_backoff = BACKOFF_NONE;
              end
            end else begin
              if (!sch_mode[1]) begin
                r.close_cmd = 1'b1;
                sch_mode[0] = 1'b0;
                sch_delay_start = w.now;
                sch_delay_on = 1'b1;
                if (sch_window != 2'd0) sch_window = sch_window - 2'd1;
                sch_backoff = (sch_backoff >= BACKOFF_NONE) ? 3'd0 : sch_backoff + 3'd1;
              end
              sch_run_start = w.now;
            end
          end
        end
      end
      KIND_FIX: begin
        sch_latest_fix = {w.lat_prefix, w.long_prefix};
        sch_fix_pending = 1'b1;
      end
      KIND_MANUAL: begin
        if (!cfg_enable) begin
          r.manual_rejected = 1'b1;
        end else begin
          sch_mode[1] = w.manual_on;
          if (!sch_mode[0]) begin
            if (w.manual_on) r.open_cmd = 1'b1;
            else r.close_cmd = 1'b1;
          end
        end
      end
      default: begin
        sch_run_start = w.now;
      end
    endcase
    r.work_mode = sch_mode;
    return r;
  endfunction

  // Check every result word taken off the output, and log every word taken in.
  always @(posedge clk) begin
    if (rst_n) begin
      if (pop && !empty) begin
        if (pending_results.size() == 0) begin
          note($sformatf("unexpected result word %h", out_data));
        end else begin
          exp_word = pending_results.pop_front();
          if (exp_word.open_cmd !== out_data.open_cmd ||
              exp_word.close_cmd !== out_data.close_cmd ||
              exp_word.record_fix !== out_data.record_fix ||
              exp_word.record_lat !== out_data.record_lat ||
              exp_word.record_long !== out_data.record_long ||
              exp_word.flush !== out_data.flush ||
              exp_word.flush_count !== out_data.flush_count ||
              exp_word.work_mode !== out_data.work_mode ||
              exp_word.manual_rejected !== out_data.manual_rejected)
            note($sformatf({"result mismatch (exp/act): open %b/%b close %b/%b rec %b/%b",
                            " lat %h/%h long %h/%h flush %b/%b count %0d/%0d",
                            " mode %0d/%0d rejected %b/%b"},
                           exp_word.open_cmd, out_data.open_cmd,
                           exp_word.close_cmd, out_data.close_cmd,
                           exp_word.record_fix, out_data.record_fix,
                           exp_word.record_lat, out_data.record_lat,
                           exp_word.record_long, out_data.record_long,
                           exp_word.flush, out_data.flush,
                           exp_word.flush_count, out_data.flush_count,
                           exp_word.work_mode, out_data.work_mode,
                           exp_word.manual_rejected, out_data.manual_rejected));
        end
      end
      if (push && !full) begin
        // Run the predictor on every word so its state tracks the block,
        // even where the table pins the expected word.
        pin_entry = pinned_results.pop_front();
        step_word = schedule_step(in_data);
        pending_results.push_back(pin_entry.pinned ? pin_entry.word : step_word);
      end
      // Watchdog: drop out if neither side moves for too long.
      if ((push && !full) || (pop && !empty)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
          $display("TEST FAILED");
          $finish;
        end
      end
    end
    pop <= calm || ($urandom_range(99) >= 26);
  end

  // Hand one word to the input side; return at the edge that takes it, with push still high.
  task automatic send_word(input in_item_t w, input logic pinned, input out_item_t want);
    if (!calm) begin
      while ($urandom_range(99) < 26) begin
        push <= 1'b0;
        @(posedge clk);
      end
    end
    pinned_results.push_back({pinned, want});
    in_data <= w;
    push <= 1'b1;
    @(posedge clk);
    while (full) @(posedge clk);
    words_sent++;
  endtask

  // Hold the input side until every expected word is out and the pipeline is quiet.
  task automatic drain_results;
    push <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input reg_idx_t r, input logic [31:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {r, 2'b00};
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (r)
      REG_GPS_ENABLE:   cfg_enable = v[0];
      REG_GET_INTERVAL: cfg_get_min = v[7:0];
      default:          cfg_send_min = v[7:0];
    endcase
    @(posedge clk);
  endtask

  task automatic cfg_check(input reg_idx_t r, input logic [31:0] want);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {r, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== want)
      note($sformatf("register %0d read back %h, expected %h", r, prdata, want));
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Drain, program all three registers, read them back, let the tick conversion settle.
  task automatic apply_settings(input logic en, input logic [7:0] get_min,
                                input logic [7:0] send_min);
    drain_results;
    cfg_write(REG_GPS_ENABLE, {31'd0, en});
    cfg_write(REG_GET_INTERVAL, {24'd0, get_min});
    cfg_write(REG_SEND_INTERVAL, {24'd0, send_min});
    cfg_check(REG_GPS_ENABLE, {31'd0, en});
    cfg_check(REG_GET_INTERVAL, {24'd0, get_min});
    cfg_check(REG_SEND_INTERVAL, {24'd0, send_min});
    repeat (4) @(posedge clk);
  endtask

  function automatic in_item_t ev(input kind_t k, input logic [31:0] t, input logic sim,
                                  input logic [23:0] lat, input logic [31:0] lng,
                                  input logic on);
    in_item_t w;
    w.kind = k;
    w.now = t;
    w.sim_ready = sim;
    w.lat_prefix = lat;
    w.long_prefix = lng;
    w.manual_on = on;
    return w;
  endfunction

  // Event with random filler in the fix prefixes and the manual flag.
  function automatic in_item_t rnd_ev(input kind_t k, input logic [31:0] t, input logic sim);
    return ev(k, t, sim, 24'($urandom), $urandom, 1'($urandom_range(1)));
  endfunction

  task automatic row(input in_item_t w, input logic pinned, input out_item_t want);
    plan.push_back({w, pinned, want});
  endtask

  // One well-formed duty cycle: open on a poll, receiver start, a fix, then close or expire.
  task automatic send_episode;
    int          span;
    logic [23:0] lat;
    logic [31:0] lng;
    span = 6000 * ((cfg_get_min >= 8'd1 && cfg_get_min <= 8'd60) ? int'(cfg_get_min) : 3);
    tb_now = tb_now + $urandom_range(0, 2 * span);
    send_word(rnd_ev(KIND_POLL, tb_now, $urandom_range(9) != 0), 1'b0, blank);
    tb_now = tb_now + $urandom_range(0, 200);
    send_word(rnd_ev(KIND_STARTED, tb_now, 1'($urandom_range(1))), 1'b0, blank);
    if ($urandom_range(6) == 0)
      send_word(rnd_ev(KIND_MANUAL, tb_now, 1'($urandom_range(1))), 1'b0, blank);
    repeat ($urandom_range(0, 2)) begin
      tb_now = tb_now + $urandom_range(0, 4000);
      send_word(rnd_ev(KIND_POLL, tb_now, $urandom_range(9) != 0), 1'b0, blank);
    end
    // Reuse a handful of prefixes so that repeated positions are deduplicated.
    case ($urandom_range(5))
      0:       begin lat = 24'h333930; lng = 32'h31313630; end
      1:       begin lat = 24'h323231; lng = 32'h31313335; end
      2:       begin lat = 24'h000000; lng = 32'h00000000; end
      default: begin lat = 24'($urandom); lng = $urandom; end
    endcase
    send_word(ev(KIND_FIX, tb_now, 1'($urandom_range(1)), lat, lng, 1'($urandom_range(1))),
              1'b0, blank);
    case ($urandom_range(9))
      0, 1, 2, 3, 4: tb_now = tb_now + $urandom_range(0, 3000);
      5, 6, 7:       tb_now = tb_now + $urandom_range(0, 40000);
      default:       tb_now = tb_now + $urandom_range(0, 150000);
    endcase
    send_word(rnd_ev(KIND_POLL, tb_now, $urandom_range(9) != 0), 1'b0, blank);
    if ($urandom_range(2) == 0) begin
      tb_now = tb_now + $urandom_range(20000, 130000);
      send_word(rnd_ev(KIND_POLL, tb_now, $urandom_range(9) != 0), 1'b0, blank);
    end
  endtask

  // Any kind, any fields; sometimes the tick count jumps anywhere, backward included.
  task automatic send_noise;
    if ($urandom_range(1) == 0) tb_now = $urandom;
    else tb_now = tb_now + $urandom_range(0, 50000);
    send_word(ev(kind_t'($urandom_range(3)), tb_now, 1'($urandom_range(1)), 24'($urandom),
                 $urandom, 1'($urandom_range(1))), 1'b0, blank);
  endtask

  task automatic random_phase(input logic en, input logic [7:0] get_min,
                              input logic [7:0] send_min, input int count, input bit quiet,
                              input bit hold_mid);
    int first;
    bit held;
    apply_settings(en, get_min, send_min);
    calm = quiet;
    first = words_sent;
    held = 1'b0;
    while (words_sent - first < count) begin
      if (hold_mid && !held && words_sent - first >= count / 2) begin
        // Hold the sender until the output side has caught up completely.
        drain_results;
        held = 1'b1;
      end
      if ($urandom_range(99) < 70) send_episode;
      else send_noise;
    end
    calm = 1'b0;
  endtask

  // Record far more distinct fixes than the buffer holds within one send period.
  // Alternating between two ticks keeps every poll past the get interval
  // (one way the difference wraps) while staying inside the send interval.
  task automatic fill_buffer;
    logic [31:0] base;
    logic [31:0] t;
    int          k;
    apply_settings(1'b1, 8'd1, 8'd60);
    base = tb_now + 32'd400000;
    send_word(rnd_ev(KIND_POLL, base, 1'b1), 1'b0, blank);
    send_word(rnd_ev(KIND_STARTED, base, 1'b1), 1'b0, blank);
    send_word(rnd_ev(KIND_POLL, base, 1'b1), 1'b0, blank);
    for (k = 0; k < 80; k++) begin
      t = base + ((k % 2 != 0) ? 32'd300000 : 32'd1000);
      send_word(rnd_ev(KIND_STARTED, t, 1'($urandom_range(1))), 1'b0, blank);
      send_word(rnd_ev(KIND_FIX, t, 1'($urandom_range(1))), 1'b0, blank);
      send_word(rnd_ev(KIND_POLL, t, 1'b1), 1'b0, blank);
    end
    // Past the send interval: hand off the whole buffer at once.
    tb_now = base + 32'd400000;
    send_word(rnd_ev(KIND_POLL, tb_now, 1'b1), 1'b0, blank);
  endtask

  initial begin : main
    int i;
    int split;
    blank = '0;
    refused = '0;
    refused.manual_rejected = 1'b1;

    // Reset state of the predictor and its registers.
    cfg_enable = 1'b0;
    cfg_get_min = 8'd3;
    cfg_send_min = 8'd3;
    sch_last_get = '0;
    sch_last_send = '0;
    sch_run_start = '0;
    sch_delay_start = '0;
    sch_delay_on = 1'b0;
    sch_window = 2'd0;
    sch_backoff = BACKOFF_NONE;
    sch_mode = 2'd0;
    sch_fix_pending = 1'b0;
    sch_latest_fix = '0;
    sch_last_recorded = '0;
    sch_record_count = 8'd0;

    // Right after reset, positioning is disabled: nothing moves, manual requests bounce.
    row(ev(KIND_POLL, 32'd0, 1'b1, 24'd0, 32'd0, 1'b0), 1'b1, blank);
    row(ev(KIND_MANUAL, 32'd0, 1'b0, 24'd0, 32'd0, 1'b1), 1'b1, refused);
    row(ev(KIND_MANUAL, 32'hFFFFFFFF, 1'b1, 24'hFFFFFF, 32'hFFFFFFFF, 1'b0), 1'b1, refused);
    row(ev(KIND_FIX, 32'd0, 1'b0, 24'hFFFFFF, 32'hFFFFFFFF, 1'b1), 1'b1, blank);
    row(ev(KIND_STARTED, 32'hFFFFFFFF, 1'b1, 24'd0, 32'd0, 1'b0), 1'b1, blank);
    row(ev(KIND_POLL, 32'hFFFFFFFF, 1'b0, 24'd0, 32'd0, 1'b0), 1'b1, blank);
    split = plan.size();
    // Enabled, 1 minute get, 3 minute send: open, consume the held fix across the
    // wrap, record zeros, flush, manual hold-over, window expiry and backoff delays.
    row(ev(KIND_POLL, 32'd100, 1'b1, 24'd0, 32'd0, 1'b0), 1'b0, blank);
    row(ev(KIND_POLL, 32'd6000, 1'b1, 24'd0, 32'd0, 1'b0), 1'b0, blank);
    row(ev(KIND_STARTED, 32'd6100, 1'b0, 24'd0, 32'd0, 1'b0), 1'b0, blank);
    row(ev(KIND_POLL, 32'd12000, 1'b1, 24'd0, 32'd0, 1'b0), 1'b0, blank);
    row(ev(KIND_FIX, 32'd12000, 1'b0, 24'd0, 32'd0, 1'b0), 1'b0, blank);
    row(ev(KIND_POLL, 32'd12100, 1'b0, 24'd0, 32'd0, 1'b0), 1'b0, blank);
    row(ev(KIND_MANUAL, 32'd12100, 1'b0, 24'd0, 32'd0, 1'b1), 1'b0, blank);
    row(ev(KIND_POLL, 32'd18000, 1'b1, 24'd0, 32'd0, 1'b0), 1'b0, blank);
    row(ev(KIND_POLL, 32'd40000, 1'b0, 24'd0, 32'd0, 1'b0), 1'b0, blank);
    row(ev(KIND_MANUAL, 32'd40000, 1'b0, 24'd0, 32'd0, 1'b0), 1'b0, blank);
    row(ev(KIND_POLL, 32'd70000, 1'b0, 24'd0, 32'd0, 1'b0), 1'b0, blank);
    row(ev(KIND_POLL, 32'd90000, 1'b1, 24'd0, 32'd0, 1'b0), 1'b0, blank);
    row(ev(KIND_POLL, 32'd100000, 1'b1, 24'd0, 32'd0, 1'b0), 1'b0, blank);
    row(ev(KIND_POLL, 32'd100000, 1'b1, 24'd0, 32'd0, 1'b0), 1'b0, blank);
    row(ev(KIND_STARTED, 32'd100001, 1'b1, 24'd0, 32'd0, 1'b0), 1'b0, blank);
    row(ev(KIND_FIX, 32'd100001, 1'b1, 24'h123456, 32'h89ABCDEF, 1'b0), 1'b0, blank);
    row(ev(KIND_POLL, 32'd100002, 1'b1, 24'd0, 32'd0, 1'b0), 1'b0, blank);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (i = 0; i < split; i++) send_word(plan[i].word, plan[i].pinned, plan[i].want);
    apply_settings(1'b1, 8'd1, 8'd3);
    for (i = split; i < plan.size(); i++) send_word(plan[i].word, plan[i].pinned, plan[i].want);
    tb_now = 32'd100002;

    // Walk the interval settings through their edges and out of range on both sides.
    random_phase(1'b1, 8'd1, 8'd3, 200, 1'b0, 1'b1);
    random_phase(1'b1, 8'd60, 8'd60, 200, 1'b1, 1'b0);
    random_phase(1'b1, 8'd0, 8'd2, 200, 1'b0, 1'b0);
    random_phase(1'b1, 8'd61, 8'd255, 200, 1'b0, 1'b0);
    random_phase(1'b0, 8'd255, 8'd0, 150, 1'b0, 1'b0);
    random_phase(1'b1, 8'd2, 8'd61, 200, 1'b0, 1'b0);
    fill_buffer;
    random_phase(1'b1, 8'($urandom), 8'($urandom), 200, 1'b0, 1'b0);
    random_phase(1'b1, 8'd1, 8'd3, 150, 1'b0, 1'b0);

    drain_results;
    repeat (10) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: gps_duty_cycle_scheduler.f
rtl/gdcs_pkg.sv
rtl/gdcs_fifo.sv
rtl/gdcs_front.sv
rtl/gdcs_back.sv
rtl/gps_duty_cycle_scheduler.sv
rtl/gdcs_checker.sv
dv/gps_duty_cycle_scheduler_test.sv
